// ----- src/cpsm_pkg.sv -----
// Shared types, constants and widths for the cubic potential space map block.
package cpsm_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_PAIRS_DEF = 16;

    // Quotient, sum, root operand and root widths of the fixed point datapath
    localparam int QW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 2;
    localparam int VW = 2 * FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 2;
    localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_READ   = 13'b0000000000010,
        ST_AX_MUL = 13'b0000000000100,
        ST_AX_CHK = 13'b0000000001000,
        ST_AX_DIV = 13'b0000000010000,
        ST_AX_SQ  = 13'b0000000100000,
        ST_SQ_GO  = 13'b0000001000000,
        ST_SQ_WT  = 13'b0000010000000,
        ST_W1     = 13'b0000100000000,
        ST_W2     = 13'b0001000000000,
        ST_K_GO   = 13'b0010000000000,
        ST_K_WT   = 13'b0100000000000,
        ST_STEP   = 13'b1000000000000
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PROD,
        OP_QSQ,
        OP_WSQ,
        OP_WCUBE,
        OP_STEP
    } t_op;

    typedef struct packed {
        logic       load_pt;
        logic       wr_mem;
        logic       rd_mem;
        logic       clr_sum;
        logic       div_start;
        logic       div_k;
        logic       sqrt_start;
        logic       load_out;
        t_op        op;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic rm_zero;
        logic far;
        logic div_done;
        logic sqrt_done;
        logic s_far;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic [2:0][31:0] tgt;
        logic [2:0][31:0] src;
        logic [2:0][31:0] rat;
    } t_pair;

endpackage

// ----- src/cpsm_if.sv -----
// Request, result and configuration channel interfaces.
interface cpsm_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [3:0]         pair_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic signed [31:0] ratio_x;
    logic signed [31:0] ratio_y;
    logic signed [31:0] ratio_z;
    modport source (output valid, cmd, pair_index, point_x, point_y, point_z,
                    source_x, source_y, source_z, ratio_x, ratio_y, ratio_z,
                    input ready);
    modport sink (input valid, cmd, pair_index, point_x, point_y, point_z,
                  source_x, source_y, source_z, ratio_x, ratio_y, ratio_z,
                  output ready);
endinterface

interface cpsm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mapped_x;
    logic signed [31:0] mapped_y;
    logic signed [31:0] mapped_z;
    logic               saturated;
    modport source (output valid, mapped_x, mapped_y, mapped_z, saturated, input ready);
    modport sink (input valid, mapped_x, mapped_y, mapped_z, saturated, output ready);
endinterface

interface cpsm_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] pair_count;
    modport source (output valid, pair_count, input ready);
    modport sink (input valid, pair_count, output ready);
endinterface

// ----- src/cpsm_div.sv -----
// Restoring fractional divider: floor(a * 2^(QW-1) / b) for a <= b, one bit a cycle.
module cpsm_div #(
    parameter int W  = 64,
    parameter int QW = cpsm_pkg::QW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_a,
    input  logic [W-1:0]  i_b,
    output logic          o_done,
    output logic [QW-1:0] o_q
);
    localparam int CW = $clog2(QW);

    logic [W-1:0]  r_r;
    logic [W-1:0]  r_b;
    logic [QW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    w_sh;
    logic          w_ge;

    // Shift the partial remainder and trial-subtract the divisor
    assign w_sh = {r_r, 1'b0};
    assign w_ge = w_sh >= {1'b0, r_b};

    // Control: busy flag, iteration count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: integer bit first, then one fraction bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_b <= i_b;
            if (i_a >= i_b) begin
                r_r <= i_a - i_b;
                r_q <= QW'(1);
            end else begin
                r_r <= i_a;
                r_q <= '0;
            end
        end else if (r_busy) begin
            r_r <= w_ge ? W'(w_sh - {1'b0, r_b}) : W'(w_sh);
            r_q <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// ----- src/cpsm_sqrt.sv -----
// Bit-pair integer square root, floor result, one result bit a cycle.
module cpsm_sqrt #(
    parameter int VW = cpsm_pkg::VW,
    parameter int RW = cpsm_pkg::RW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_v,
    output logic          o_done,
    output logic [RW-1:0] o_s
);
    localparam int CW = $clog2(VW / 2 + 1);

    logic [VW-1:0] r_v;
    logic [VW-1:0] r_res;
    logic [VW-1:0] r_bit;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   w_t;

    assign w_t = {1'b0, r_res} + {1'b0, r_bit};

    // Control: busy flag, iteration count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VW / 2);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: try each bit pair from the top down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_v;
            r_res <= '0;
            r_bit <= VW'(1) << (VW - 2);
        end else if (r_busy) begin
            if ({1'b0, r_v} >= w_t) begin
                r_v   <= VW'({1'b0, r_v} - w_t);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_s    = RW'(r_res);
endmodule

// ----- src/cpsm_ctrl.sv -----
// Sequencer: walks each map request over the control pairs and their axes.
module cpsm_ctrl #(
    parameter  int MAX_PAIRS = cpsm_pkg::MAX_PAIRS_DEF,
    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_cmd,
    output logic             o_in_ready,
    input  logic             i_cfg_valid,
    input  logic [4:0]       i_cfg_pair_count,
    output logic             o_cfg_ready,
    input  cpsm_pkg::t_stat  i_stat,
    output cpsm_pkg::t_cmd   o_cmd,
    output logic [AW-1:0]    o_rd_addr
);
    localparam int PW = $clog2(MAX_PAIRS + 1);

    cpsm_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_pair, n_pair;
    logic [1:0]       r_axis, n_axis;
    logic [4:0]       r_pair_count;
    logic [PW-1:0]    w_n;
    logic             w_last;
    cpsm_pkg::t_state w_after_pair;

    // Clamp the pair count to the table depth
    assign w_n = (int'(r_pair_count) > MAX_PAIRS) ? PW'(MAX_PAIRS) : PW'(r_pair_count);
    assign w_last = ({1'b0, r_pair} + 1'b1) >= {1'b0, w_n};
    assign w_after_pair = w_last ? cpsm_pkg::ST_IDLE : cpsm_pkg::ST_READ;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        n_pair     = r_pair;
        n_axis     = r_axis;
        o_cmd      = '0;
        o_cmd.op   = cpsm_pkg::OP_NONE;
        o_cmd.axis = r_axis;
        o_in_ready = 1'b0;
        case (r_state)
            cpsm_pkg::ST_IDLE: begin
                o_in_ready = !i_stat.out_busy;
                if (i_in_valid && !i_stat.out_busy) begin
                    if (i_in_cmd == cpsm_pkg::CMD_MAP) begin
                        o_cmd.load_pt = 1'b1;
                        n_pair = '0;
                        if (w_n == '0) begin
                            o_cmd.load_out = 1'b1;
                        end else begin
                            n_state = cpsm_pkg::ST_READ;
                        end
                    end else begin
                        o_cmd.wr_mem = 1'b1;
                    end
                end
            end
            cpsm_pkg::ST_READ: begin
                o_cmd.rd_mem  = 1'b1;
                o_cmd.clr_sum = 1'b1;
                n_axis  = '0;
                n_state = cpsm_pkg::ST_AX_MUL;
            end
            cpsm_pkg::ST_AX_MUL: begin
                if (i_stat.rm_zero) begin
                    n_pair  = r_pair + 1'b1;
                    n_state = w_after_pair;
                end else begin
                    o_cmd.op = cpsm_pkg::OP_PROD;
                    n_state  = cpsm_pkg::ST_AX_CHK;
                end
            end
            cpsm_pkg::ST_AX_CHK: begin
                if (i_stat.far) begin
                    n_pair  = r_pair + 1'b1;
                    n_state = w_after_pair;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = cpsm_pkg::ST_AX_DIV;
                end
            end
            cpsm_pkg::ST_AX_DIV: begin
                if (i_stat.div_done) begin
                    n_state = cpsm_pkg::ST_AX_SQ;
                end
            end
            cpsm_pkg::ST_AX_SQ: begin
                o_cmd.op = cpsm_pkg::OP_QSQ;
                if (r_axis == 2'd2) begin
                    n_state = cpsm_pkg::ST_SQ_GO;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = cpsm_pkg::ST_AX_MUL;
                end
            end
            cpsm_pkg::ST_SQ_GO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = cpsm_pkg::ST_SQ_WT;
            end
            cpsm_pkg::ST_SQ_WT: begin
                if (i_stat.sqrt_done) begin
                    n_state = cpsm_pkg::ST_W1;
                end
            end
            cpsm_pkg::ST_W1: begin
                if (i_stat.s_far) begin
                    n_pair  = r_pair + 1'b1;
                    n_state = w_after_pair;
                end else begin
                    o_cmd.op = cpsm_pkg::OP_WSQ;
                    n_state  = cpsm_pkg::ST_W2;
                end
            end
            cpsm_pkg::ST_W2: begin
                o_cmd.op = cpsm_pkg::OP_WCUBE;
                n_state  = cpsm_pkg::ST_K_GO;
            end
            cpsm_pkg::ST_K_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_k     = 1'b1;
                n_state = cpsm_pkg::ST_K_WT;
            end
            cpsm_pkg::ST_K_WT: begin
                if (i_stat.div_done) begin
                    n_axis  = '0;
                    n_state = cpsm_pkg::ST_STEP;
                end
            end
            cpsm_pkg::ST_STEP: begin
                o_cmd.op = cpsm_pkg::OP_STEP;
                if (r_axis == 2'd2) begin
                    n_pair  = r_pair + 1'b1;
                    n_state = w_after_pair;
                end else begin
                    n_axis = r_axis + 1'b1;
                end
            end
            default: begin
                n_state = cpsm_pkg::ST_IDLE;
            end
        endcase
        // Deliver the result as the walk over the pairs ends
        if (r_state != cpsm_pkg::ST_IDLE && n_state == cpsm_pkg::ST_IDLE) begin
            o_cmd.load_out = 1'b1;
        end
    end

    // State, counters and the pair count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cpsm_pkg::ST_IDLE;
            r_pair       <= '0;
            r_axis       <= '0;
            r_pair_count <= '0;
        end else begin
            r_state <= n_state;
            r_pair  <= n_pair;
            r_axis  <= n_axis;
            if (i_cfg_valid) begin
                r_pair_count <= i_cfg_pair_count;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_rd_addr   = r_pair[AW-1:0];
endmodule

// ----- src/cpsm_dp.sv -----
// Datapath: pair table, point registers, shared multiplier, divider and root units.
module cpsm_dp #(
    parameter  int MAX_PAIRS = cpsm_pkg::MAX_PAIRS_DEF,
    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpsm_pkg::t_cmd     i_cmd,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [3:0]         i_pair_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_source_x,
    input  logic signed [31:0] i_source_y,
    input  logic signed [31:0] i_source_z,
    input  logic signed [31:0] i_ratio_x,
    input  logic signed [31:0] i_ratio_y,
    input  logic signed [31:0] i_ratio_z,
    input  logic               i_out_ready,
    output cpsm_pkg::t_stat    o_stat,
    output logic               o_out_valid,
    output logic signed [31:0] o_mapped_x,
    output logic signed [31:0] o_mapped_y,
    output logic signed [31:0] o_mapped_z,
    output logic               o_saturated
);
    localparam int F  = cpsm_pkg::FRAC_BITS;
    localparam int QW = cpsm_pkg::QW;
    localparam int SW = cpsm_pkg::SW;
    localparam int VW = cpsm_pkg::VW;
    localparam int RW = cpsm_pkg::RW;

    cpsm_pkg::t_pair    r_mem [MAX_PAIRS];
    cpsm_pkg::t_pair    r_ent;
    cpsm_pkg::t_pair    w_wr;
    logic signed [31:0] r_p [3];
    logic               r_sat;
    logic [SW-1:0]      r_sum;
    logic [63:0]        r_prod;
    logic [QW-1:0]      r_c;
    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y, r_out_z;
    logic               r_out_sat;

    logic signed [31:0] w_tg, w_sr, w_rt, w_pa;
    logic signed [32:0] w_d, w_dp;
    logic [32:0]        w_ad, w_rm, w_nm;
    logic [63:0]        w_num;
    logic [QW-1:0]      w_q;
    logic [RW-1:0]      w_s;
    logic [QW-1:0]      w_w;
    logic [32:0]        w_ma, w_mb;
    logic [65:0]        w_mp;
    logic [65:0]        w_mp_sh;
    logic signed [34:0] w_step, w_newp;
    logic               w_ovf;
    logic signed [31:0] w_upd;
    logic               w_upd_x, w_upd_y, w_upd_z;
    logic [63:0]        w_div_a, w_div_b;
    logic               w_div_done, w_sqrt_done;

    // Pack a load request into a table row, x in element 0
    assign w_wr.tgt = {i_point_z, i_point_y, i_point_x};
    assign w_wr.src = {i_source_z, i_source_y, i_source_x};
    assign w_wr.rat = {i_ratio_z, i_ratio_y, i_ratio_x};

    // Pair table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_mem && (int'(i_pair_index) < MAX_PAIRS)) begin
            r_mem[AW'(i_pair_index)] <= w_wr;
        end
        if (i_cmd.rd_mem) begin
            r_ent <= r_mem[i_rd_addr];
        end
    end

    // Per-axis operands of the current pair
    assign w_tg  = signed'(r_ent.tgt[i_cmd.axis]);
    assign w_sr  = signed'(r_ent.src[i_cmd.axis]);
    assign w_rt  = signed'(r_ent.rat[i_cmd.axis]);
    assign w_pa  = r_p[i_cmd.axis];
    assign w_d   = 33'(w_tg) - 33'(w_sr);
    assign w_ad  = w_d[32] ? 33'(-w_d) : 33'(w_d);
    assign w_rm  = w_rt[31] ? 33'(-33'(w_rt)) : 33'(w_rt);
    assign w_dp  = 33'(w_pa) - 33'(w_tg);
    assign w_nm  = w_dp[32] ? 33'(-w_dp) : 33'(w_dp);
    assign w_num = 64'(w_nm) << F;
    assign w_w   = QW'(RW'(cpsm_pkg::UNIT) - w_s);

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            cpsm_pkg::OP_PROD: begin
                w_ma = w_rm;
                w_mb = 33'(cpsm_pkg::UNIT) + w_ad;
            end
            cpsm_pkg::OP_QSQ: begin
                w_ma = 33'(w_q);
                w_mb = 33'(w_q);
            end
            cpsm_pkg::OP_WSQ: begin
                w_ma = 33'(w_w);
                w_mb = 33'(w_w);
            end
            cpsm_pkg::OP_WCUBE: begin
                w_ma = 33'(r_prod[QW-1:0]);
                w_mb = 33'(w_w);
            end
            cpsm_pkg::OP_STEP: begin
                w_ma = 33'(w_q);
                w_mb = w_ad;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mp    = 66'(w_ma) * 66'(w_mb);
    assign w_mp_sh = w_mp >> F;

    // Signed step toward the source and the saturating update
    assign w_step = w_d[32] ? -35'(w_mp_sh[33:0]) : 35'(w_mp_sh[33:0]);
    assign w_newp = 35'(w_pa) - w_step;
    assign w_ovf  = (w_newp[34:31] != 4'b0000) && (w_newp[34:31] != 4'b1111);
    assign w_upd  = w_ovf ? (w_newp[34] ? 32'sh80000000 : 32'sh7fffffff) : w_newp[31:0];

    // Axis being updated this cycle, forwarded into the result register
    assign w_upd_x = (i_cmd.op == cpsm_pkg::OP_STEP) && (i_cmd.axis == 2'd0);
    assign w_upd_y = (i_cmd.op == cpsm_pkg::OP_STEP) && (i_cmd.axis == 2'd1);
    assign w_upd_z = (i_cmd.op == cpsm_pkg::OP_STEP) && (i_cmd.axis == 2'd2);

    // Point, accumulator and product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            r_p[0] <= i_point_x;
            r_p[1] <= i_point_y;
            r_p[2] <= i_point_z;
            r_sat  <= 1'b0;
        end
        if (i_cmd.clr_sum) begin
            r_sum <= '0;
        end
        case (i_cmd.op)
            cpsm_pkg::OP_PROD:  r_prod <= w_mp[63:0];
            cpsm_pkg::OP_QSQ:   r_sum  <= r_sum + SW'(w_mp_sh);
            cpsm_pkg::OP_WSQ:   r_prod <= w_mp_sh[63:0];
            cpsm_pkg::OP_WCUBE: r_c    <= QW'(w_mp_sh);
            cpsm_pkg::OP_STEP: begin
                r_p[i_cmd.axis] <= w_upd;
                if (w_ovf) begin
                    r_sat <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Divider operands: axis quotient or the cubic weight
    assign w_div_a = i_cmd.div_k ? 64'(r_c) : w_num;
    assign w_div_b = i_cmd.div_k ? (64'(cpsm_pkg::UNIT) + 64'(w_s)) : r_prod;

    cpsm_div #(
        .W  (64),
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_a     (w_div_a),
        .i_b     (w_div_b),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    cpsm_sqrt #(
        .VW (VW),
        .RW (RW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_v     (VW'(r_sum) << F),
        .o_done  (w_sqrt_done),
        .o_s     (w_s)
    );

    // Output register: hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the point, taking the coordinate written in this same cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x   <= i_cmd.load_pt ? i_point_x : (w_upd_x ? w_upd : r_p[0]);
            r_out_y   <= i_cmd.load_pt ? i_point_y : (w_upd_y ? w_upd : r_p[1]);
            r_out_z   <= i_cmd.load_pt ? i_point_z : (w_upd_z ? w_upd : r_p[2]);
            r_out_sat <= i_cmd.load_pt ? 1'b0
                                       : (r_sat || ((i_cmd.op == cpsm_pkg::OP_STEP) && w_ovf));
        end
    end

    // Status back to the sequencer
    assign o_stat.rm_zero   = (w_rm == '0);
    assign o_stat.far       = (w_num > r_prod);
    assign o_stat.div_done  = w_div_done;
    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.s_far     = (w_s > RW'(cpsm_pkg::UNIT));
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_mapped_x  = r_out_x;
    assign o_mapped_y  = r_out_y;
    assign o_mapped_z  = r_out_z;
    assign o_saturated = r_out_sat;
endmodule

// ----- src/cubic_potential_space_map_core.sv -----
// Top level: cubic potential space map over a table of control pairs.
// Load requests give no result. A map request walks the pairs in
// order; a pair that passes every test uses the shared bit-serial divider
// four times and the bit-pair square root unit once. A pair that drops out on a zero
// ratio, a far axis or a root above one ends early. One map at a time.
// Reset (synchronous, active low) clears the sequencer, pair count and output valid.
module cubic_potential_space_map_core #(
    parameter int MAX_PAIRS = cpsm_pkg::MAX_PAIRS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cpsm_req_if.sink       i_req,
    cpsm_rsp_if.source     o_rsp,
    cpsm_cfg_if.sink       i_cfg
);
    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    cpsm_pkg::t_cmd  w_cmd;
    cpsm_pkg::t_stat w_stat;
    logic [AW-1:0]   w_rd_addr;

    cpsm_ctrl #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_req.valid),
        .i_in_cmd         (i_req.cmd),
        .o_in_ready       (i_req.ready),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_pair_count (i_cfg.pair_count),
        .o_cfg_ready      (i_cfg.ready),
        .i_stat           (w_stat),
        .o_cmd            (w_cmd),
        .o_rd_addr        (w_rd_addr)
    );

    cpsm_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_rd_addr    (w_rd_addr),
        .i_pair_index (i_req.pair_index),
        .i_point_x    (i_req.point_x),
        .i_point_y    (i_req.point_y),
        .i_point_z    (i_req.point_z),
        .i_source_x   (i_req.source_x),
        .i_source_y   (i_req.source_y),
        .i_source_z   (i_req.source_z),
        .i_ratio_x    (i_req.ratio_x),
        .i_ratio_y    (i_req.ratio_y),
        .i_ratio_z    (i_req.ratio_z),
        .i_out_ready  (o_rsp.ready),
        .o_stat       (w_stat),
        .o_out_valid  (o_rsp.valid),
        .o_mapped_x   (o_rsp.mapped_x),
        .o_mapped_y   (o_rsp.mapped_y),
        .o_mapped_z   (o_rsp.mapped_z),
        .o_saturated  (o_rsp.saturated)
    );

    // A map request with pairs to walk blocks the next request
    a_map_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.cmd == cpsm_pkg::CMD_MAP
         && w_cmd.load_out == 1'b0) |=> !i_req.ready)
        else $error("map request did not block the input");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result register overwritten");

    // Divider and root unit are never started together
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.div_start && w_cmd.sqrt_start))
        else $error("divider and root started together");
endmodule
